// ===== src/pi_controller_antiwindup_defines.svh =====
// Assertion macros for the PI controller block.
// Used by the top level only; the including module provides clk and rst.
`ifndef PI_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`define PI_CONTROLLER_ANTIWINDUP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PCA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pi controller check failed");

// Next-cycle implication, disabled during reset
`define PCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pi controller check failed");

`endif

// ===== src/pca_pkg.sv =====
// Package for the PI controller: payload structs, register codes,
// microcode control word and the microcode program. No dependencies.
package pca_pkg;

  // Number of controller instances and the width of an instance index
  localparam int NUM_CHANNELS = 2;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration port index width
  localparam int CFG_IDX_W = 3;

  // Shared multiplier: signed operands and registered product
  localparam int MUL_W  = 31;
  localparam int PROD_W = 62;
  // Drive accumulator: two products of at most 33 bits each, plus sign
  localparam int ACC_W  = 36;

  // Divide by 1000 as (x >> 3) / 125, exact for x below 2**29:
  // RECIP_125 = ceil(2**36 / 125), quotient = ((x >> 3) * RECIP_125) >> 36
  localparam int          PRE_SHIFT   = 3;
  localparam int          RECIP_SHIFT = 36;
  localparam int          RECIP_W     = 30;
  localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;
  // Quotient width: |error * elapsed| / 1000 stays below 2**23
  localparam int          QUOT_W      = 23;

  typedef struct packed {
    logic               channel;
    logic signed [15:0] target;
    logic signed [15:0] measured;
    logic        [15:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic        [15:0] drive_magnitude;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN = 3'd0,
    REG_INT_GAIN  = 3'd1,
    REG_OUT_MIN   = 3'd2,
    REG_OUT_MAX   = 3'd3,
    REG_INT_MIN   = 3'd4,
    REG_INT_MAX   = 3'd5
  } cfg_reg_t;

  // Program steps
  typedef enum logic [2:0] {
    STEP_WAIT,
    STEP_ERR_TIME,
    STEP_RECIP,
    STEP_INTEG,
    STEP_INT_GAIN,
    STEP_FINISH
  } step_t;

  typedef enum logic [1:0] {
    A_ERR_MAG,
    A_PROD_SHIFT,
    A_ERR,
    A_INTEG
  } a_sel_t;

  typedef enum logic [1:0] {
    B_ELAPSED,
    B_RECIP,
    B_PROP_GAIN,
    B_INT_GAIN
  } b_sel_t;

  // Step advance condition
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN,
    COND_OUT
  } cond_t;

  typedef struct packed {
    logic   mul_en;
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   integ_we;
    logic   acc_load;
    logic   out_we;
    cond_t  cond;
    step_t  next_step;
  } ctrl_t;

  // Microcode ROM: one control word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '{mul_en: 1'b0, a_sel: A_ERR_MAG, b_sel: B_ELAPSED, integ_we: 1'b0,
          acc_load: 1'b0, out_we: 1'b0, cond: COND_ALWAYS, next_step: STEP_WAIT};
    case (s)
      STEP_WAIT: begin
        c.cond      = COND_IN;
        c.next_step = STEP_ERR_TIME;
      end
      STEP_ERR_TIME: begin
        c.mul_en    = 1'b1;
        c.a_sel     = A_ERR_MAG;
        c.b_sel     = B_ELAPSED;
        c.next_step = STEP_RECIP;
      end
      STEP_RECIP: begin
        c.mul_en    = 1'b1;
        c.a_sel     = A_PROD_SHIFT;
        c.b_sel     = B_RECIP;
        c.next_step = STEP_INTEG;
      end
      STEP_INTEG: begin
        c.mul_en    = 1'b1;
        c.a_sel     = A_ERR;
        c.b_sel     = B_PROP_GAIN;
        c.integ_we  = 1'b1;
        c.next_step = STEP_INT_GAIN;
      end
      STEP_INT_GAIN: begin
        c.mul_en    = 1'b1;
        c.a_sel     = A_INTEG;
        c.b_sel     = B_INT_GAIN;
        c.acc_load  = 1'b1;
        c.next_step = STEP_FINISH;
      end
      STEP_FINISH: begin
        c.out_we    = 1'b1;
        c.cond      = COND_OUT;
        c.next_step = STEP_WAIT;
      end
      default: begin
        c.next_step = STEP_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/pi_controller_antiwindup.sv =====
// Multi-channel PI controller with integrator clamping, top level.
// Depends on pca_pkg and on pi_controller_antiwindup_defines.svh.
`include "pi_controller_antiwindup_defines.svh"

// An item is taken in by a transfer in the wait step, then passes through five
// microcode steps. The first four share one 31x31 signed multiplier (error
// times elapsed time, the reciprocal multiply that divides by 1000, and the
// two gain products); the last sums, clamps and loads the output register.
// The multiplier is used once in each of those four steps. One item is in
// work at a time; in_stall is high from the cycle after a transfer until
// the result lands in the output register. The output
// register holds a finished result while the next item is taken in; a result
// that is still stalled when the next one is done holds the last step until
// it leaves. Configuration writes belong in idle periods; integrators clear
// to zero on reset.
module pi_controller_antiwindup import pca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers
  logic        [15:0] prop_gain;
  logic        [15:0] int_gain;
  logic signed [15:0] out_min;
  logic signed [15:0] out_max;
  logic signed [15:0] int_min;
  logic signed [15:0] int_max;

  // Sequencer
  step_t step;
  step_t step_next;
  ctrl_t ctrl;
  logic  in_xfer;
  logic  slot_free;

  // Item registers
  logic        [CH_IDX_W-1:0] ch;
  logic signed [16:0]         err;
  logic        [15:0]         elapsed;
  logic signed [16:0]         err_in;
  logic signed [16:0]         err_neg;
  logic        [15:0]         err_mag;

  // Datapath
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod;
  logic signed [15:0]       integrator [NUM_CHANNELS];
  logic signed [15:0]       integ;
  logic signed [ACC_W-1:0]  acc;

  logic        [QUOT_W-1:0] quot;
  logic signed [QUOT_W:0]   quot_s;
  logic signed [23:0]       integ_sum;
  logic signed [15:0]       integ_new;
  logic signed [ACC_W-1:0]  drive_sum;
  logic signed [15:0]       drive_val;
  logic signed [16:0]       drive_ext;
  logic signed [16:0]       drive_abs;

  // Magnitude of the held result, for the checks
  logic        [15:0]       out_abs;

  // Handshake conditions
  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (step != STEP_WAIT);
  assign slot_free = !out_valid || !out_stall;

  // Fetch the control word of the current step
  assign ctrl = ucode(step);

  // Pick the next step
  always_comb begin
    step_next = step;
    case (ctrl.cond)
      COND_ALWAYS: step_next = ctrl.next_step;
      COND_IN:     if (in_xfer) step_next = ctrl.next_step;
      COND_OUT:    if (slot_free) step_next = ctrl.next_step;
      default:     step_next = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= 16'd10;
      int_gain  <= 16'd1;
      out_min   <= -16'sd1000;
      out_max   <= 16'sd1000;
      int_min   <= -16'sd1000;
      int_max   <= 16'sd1000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN: prop_gain <= cfg_data;
        REG_INT_GAIN:  int_gain  <= cfg_data;
        REG_OUT_MIN:   out_min   <= cfg_data;
        REG_OUT_MAX:   out_max   <= cfg_data;
        REG_INT_MIN:   int_min   <= cfg_data;
        REG_INT_MAX:   int_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item: channel, error and elapsed time
  assign err_in = 17'(in_data.target) - 17'(in_data.measured);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch      <= (NUM_CHANNELS > 1) ? CH_IDX_W'(in_data.channel) : '0;
      err     <= err_in;
      elapsed <= in_data.elapsed;
    end
  end

  // Error magnitude, fits 16 bits unsigned
  assign err_neg = -err;
  assign err_mag = err[16] ? err_neg[15:0] : err[15:0];

  // Select multiplier operands
  always_comb begin
    case (ctrl.a_sel)
      A_ERR_MAG:    mul_a = {{(MUL_W-16){1'b0}}, err_mag};
      A_PROD_SHIFT: mul_a = {{(MUL_W-32+PRE_SHIFT){1'b0}}, prod[31:PRE_SHIFT]};
      A_ERR:        mul_a = MUL_W'(err);
      A_INTEG:      mul_a = MUL_W'(integ);
      default:      mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_ELAPSED:   mul_b = {{(MUL_W-16){1'b0}}, elapsed};
      B_RECIP:     mul_b = {{(MUL_W-RECIP_W){1'b0}}, RECIP_125};
      B_PROP_GAIN: mul_b = {{(MUL_W-16){1'b0}}, prop_gain};
      B_INT_GAIN:  mul_b = {{(MUL_W-16){1'b0}}, int_gain};
      default:     mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_p;
    end
  end

  // Integrator update: signed quotient, add, clamp with the upper test first
  assign quot   = prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  assign quot_s = err[16] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign integ_sum = 24'(integrator[ch]) + 24'(quot_s);

  always_comb begin
    if (integ_sum > 24'(int_max)) begin
      integ_new = int_max;
    end else if (integ_sum < 24'(int_min)) begin
      integ_new = int_min;
    end else begin
      integ_new = integ_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        integrator[i] <= '0;
      end
    end else if (ctrl.integ_we) begin
      integrator[ch] <= integ_new;
    end
  end

  // Hold the clamped integrator and the proportional term
  always_ff @(posedge clk) begin
    if (ctrl.integ_we) begin
      integ <= integ_new;
    end
    if (ctrl.acc_load) begin
      acc <= ACC_W'(prod);
    end
  end

  // Drive: sum of both terms, clamp with the upper test first
  assign drive_sum = acc + ACC_W'(prod);

  always_comb begin
    if (drive_sum > ACC_W'(out_max)) begin
      drive_val = out_max;
    end else if (drive_sum < ACC_W'(out_min)) begin
      drive_val = out_min;
    end else begin
      drive_val = drive_sum[15:0];
    end
  end

  assign drive_ext = 17'(drive_val);
  assign drive_abs = drive_val[15] ? -drive_ext : drive_ext;

  // Output register: load when the slot is free, drop after a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_we && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_we && slot_free) begin
      out_data.drive           <= drive_val;
      out_data.drive_magnitude <= drive_abs[15:0];
    end
  end

  assign out_abs = out_data.drive[15] ? 16'(-out_data.drive) : 16'(out_data.drive);

  // Checks
  `PCA_ASSERT_NEXT(a_start_step, in_xfer, step == STEP_ERR_TIME)
  `PCA_ASSERT_NEXT(a_finish_loads, ctrl.out_we && slot_free, out_valid && !in_stall)
  `PCA_ASSERT_SAME(a_mag_match, out_valid, out_data.drive_magnitude == out_abs)

endmodule
